// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  // table geometry
  localparam int STATION_ENTRIES = 64;
  localparam int IDX_W = (STATION_ENTRIES > 1) ? $clog2(STATION_ENTRIES) : 1;
  localparam int ADDR_W = 48;
  localparam int CMD_W = 2;
  localparam int STATION_INDEX_W = 6;
  // group bit is the lsb of the first octet
  localparam int GROUP_BIT = 40;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    AS_DISASSOC = 2'd0,
    AS_WAITING  = 2'd1,
    AS_ASSOC    = 2'd2
  } assoc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_OK     = 2'd2,
    CMD_DROP   = 2'd3
  } cmd_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic   search;
    addr_t  search_key;
    logic   exec_wr;
    logic   append;
    addr_t  wr_key;
    assoc_t new_state;
  } cell_ctrl_t;

  // what each cell reports back
  typedef struct packed {
    logic   used;
    logic   match;
    assoc_t state;
  } cell_stat_t;

  // association state after a command
  function automatic assoc_t apply_command(input assoc_t cur, input cmd_t cmd);
    assoc_t res;
    case (cmd)
      CMD_WAIT: res = AS_WAITING;
      CMD_OK:   res = AS_ASSOC;
      CMD_DROP: res = AS_DISASSOC;
      default:  res = cur;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/stt_cell.sv =====
module stt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prev_used,
  input  stt_pkg::cell_ctrl_t ctrl,
  output stt_pkg::cell_stat_t stat
);

  logic            used_r;
  logic            used_nxt;
  logic            match_r;
  logic            match_nxt;
  stt_pkg::addr_t  addr_r;
  stt_pkg::assoc_t state_r;
  logic            sel;
  logic            free_slot;

  // first free cell in the row takes an appended entry
  assign free_slot = prev_used & ~used_r;
  assign sel = ctrl.exec_wr & (ctrl.append ? free_slot : match_r);

  // occupancy and match flags
  always_comb begin
    used_nxt = used_r | (sel & ctrl.append);
    match_nxt = match_r;
    if (ctrl.search) begin
      match_nxt = used_r & (addr_r == ctrl.search_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      match_r <= match_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (sel) begin
      state_r <= ctrl.new_state;
      if (ctrl.append) begin
        addr_r <= ctrl.wr_key;
      end
    end
  end

  assign stat.used  = used_r;
  assign stat.match = match_r;
  assign stat.state = state_r;

endmodule

// ===== rtl/station_table_with_assoc_state.sv =====
// the item is captured when accepted and executed in the exec state, where the result
//   goes to the output register; no new item is taken before that; the cell row registers
//   its address compares in the accept cycle and the selected cell is updated on execution
// a stalled result holds the next item back until the output register frees
// reset: table empty, group entry disassociated, no item or result pending
module station_table_with_assoc_state (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stt_pkg::CMD_W-1:0]           in_command,
  input  logic [stt_pkg::ADDR_W-1:0]          in_peer_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stt_pkg::STATION_INDEX_W-1:0] out_station_index,
  output logic                                out_is_group,
  output logic                                out_was_created,
  output logic                                out_table_full,
  output logic                                out_associated,
  output logic                                out_waiting_assoc
);

  stt_pkg::fsm_t       state_r;
  stt_pkg::fsm_t       state_nxt;
  logic                in_fire;
  logic                exec_go;
  logic                out_free;

  stt_pkg::addr_t      key_r;
  stt_pkg::cmd_t       cmd_r;
  logic                group_r;
  stt_pkg::assoc_t     group_state_r;
  stt_pkg::assoc_t     group_state_nxt;

  stt_pkg::cell_ctrl_t ctrl;
  stt_pkg::cell_stat_t stat [stt_pkg::STATION_ENTRIES];
  logic                prev_used [stt_pkg::STATION_ENTRIES];

  logic                hit;
  stt_pkg::idx_t       hit_idx;
  logic [1:0]          hit_state;
  stt_pkg::idx_t       app_idx;
  logic                full;
  stt_pkg::assoc_t     res_state;
  stt_pkg::idx_t       res_idx;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [stt_pkg::STATION_INDEX_W-1:0] idx_out_r;
  logic                group_out_r;
  logic                created_out_r;
  logic                full_out_r;
  logic                assoc_out_r;
  logic                wait_out_r;

  // control sequence
  assign out_free = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::FSM_IDLE: begin
        if (in_valid) state_nxt = stt_pkg::FSM_EXEC;
      end
      stt_pkg::FSM_EXEC: begin
        if (out_free) state_nxt = stt_pkg::FSM_IDLE;
      end
      default: state_nxt = stt_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      stt_pkg::FSM_IDLE: in_ready = 1'b1;
      stt_pkg::FSM_EXEC: exec_go = out_free;
      default: begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stt_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r   <= in_peer_address;
      cmd_r   <= stt_pkg::cmd_t'(in_command);
      group_r <= in_peer_address[stt_pkg::GROUP_BIT];
    end
  end

  // collapse the one-hot match row and find the first free cell
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    hit_state = '0;
    app_idx   = '0;
    for (int i = 0; i < stt_pkg::STATION_ENTRIES; i++) begin
      hit = hit | stat[i].match;
      if (stat[i].match) begin
        hit_idx   = hit_idx | stt_pkg::IDX_W'(i);
        hit_state = hit_state | stat[i].state;
      end
      if (prev_used[i] && !stat[i].used) begin
        app_idx = app_idx | stt_pkg::IDX_W'(i);
      end
    end
    full = stat[stt_pkg::STATION_ENTRIES-1].used;
  end

  // resulting entry state and index
  always_comb begin
    if (group_r) begin
      res_state = stt_pkg::apply_command(group_state_r, cmd_r);
      res_idx   = '0;
    end else if (hit) begin
      res_state = stt_pkg::apply_command(stt_pkg::assoc_t'(hit_state), cmd_r);
      res_idx   = hit_idx;
    end else begin
      res_state = stt_pkg::apply_command(stt_pkg::AS_DISASSOC, cmd_r);
      res_idx   = app_idx;
    end
  end

  // broadcast to the cell row
  always_comb begin
    ctrl.search     = in_fire;
    ctrl.search_key = in_peer_address;
    ctrl.exec_wr    = exec_go & ~group_r & (hit | ~full);
    ctrl.append     = ~hit;
    ctrl.wr_key     = key_r;
    ctrl.new_state  = res_state;
  end

  // row of entry cells, occupancy handed down the chain
  for (genvar g = 0; g < stt_pkg::STATION_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_used[g] = 1'b1;
    end else begin : g_body
      assign prev_used[g] = stat[g-1].used;
    end
    stt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .prev_used (prev_used[g]),
      .ctrl      (ctrl),
      .stat      (stat[g])
    );
  end

  // shared group entry
  always_comb begin
    group_state_nxt = group_state_r;
    if (exec_go && group_r) group_state_nxt = res_state;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_state_r <= stt_pkg::AS_DISASSOC;
    end else begin
      group_state_r <= group_state_nxt;
    end
  end

  // output register
  assign out_valid_nxt = exec_go | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      if (!group_r && !hit && full) begin
        idx_out_r     <= '0;
        group_out_r   <= 1'b0;
        created_out_r <= 1'b0;
        full_out_r    <= 1'b1;
        assoc_out_r   <= 1'b0;
        wait_out_r    <= 1'b0;
      end else begin
        idx_out_r     <= stt_pkg::STATION_INDEX_W'(res_idx);
        group_out_r   <= group_r;
        created_out_r <= ~group_r & ~hit;
        full_out_r    <= 1'b0;
        assoc_out_r   <= (res_state == stt_pkg::AS_ASSOC);
        wait_out_r    <= (res_state == stt_pkg::AS_WAITING);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_station_index = idx_out_r;
  assign out_is_group      = group_out_r;
  assign out_was_created   = created_out_r;
  assign out_table_full    = full_out_r;
  assign out_associated    = assoc_out_r;
  assign out_waiting_assoc = wait_out_r;

endmodule

// ===== rtl/stt_check.sv =====
module stt_check (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [stt_pkg::STATION_INDEX_W-1:0] out_station_index,
  input logic                                out_is_group,
  input logic                                out_was_created,
  input logic                                out_table_full,
  input logic                                out_associated,
  input logic                                out_waiting_assoc
);

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // full table reports nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_station_index == '0 && !out_was_created &&
      !out_is_group && !out_associated && !out_waiting_assoc)
    else $error("table full result carries entry data");

  // group items use the shared entry only
  a_group_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_group |-> out_station_index == '0 && !out_was_created &&
      !out_table_full)
    else $error("group item touched the station row");

  // states are exclusive
  a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_associated && out_waiting_assoc))
    else $error("associated and waiting both set");

  // no item is taken while a result is being formed
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before result formed");

endmodule

bind station_table_with_assoc_state stt_check u_stt_check (.*);
